// ===== src/mts_pkg.sv =====
// Shared constants, codes and control types for the min-tracking stack.
// Depends on nothing; the controller, datapath and top refer to it by scoped names.
package mts_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int VALUE_WIDTH  = 32;
    localparam int ENTRY_WIDTH  = VALUE_WIDTH + 2;
    localparam int ADDR_WIDTH   = $clog2(STACK_DEPTH);
    localparam int PTR_WIDTH    = $clog2(STACK_DEPTH + 1);
    localparam int STATUS_WIDTH = 2;

    // Operation codes carried on the mode field
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic do_push;
        logic do_pop;
    } mts_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } mts_stat_t;

endpackage

// ===== src/min_tracking_stack_top.sv =====
// A stack of signed values that reports its minimum on every push and pop, with
// no second stack: a push below the current minimum stores 2*value - min and a
// pop of an entry at or below the minimum restores the previous minimum from it.
// Each beat is taken in the idle state, where the top entry is read from the stack
// store, whose read data is registered; in the push or pop state that follows,
// pointer and minimum update and the result register loads, so the result beat is
// valid once that register holds it. The push or pop state is held while an earlier
// result beat is still stalled. A finished result waits in its own register, so the
// next beat is taken while it is outstanding. A push on a full stack and a pop on
// an empty stack change nothing and are flagged in status.
// Depends on mts_pkg, mts_ctrl, mts_datapath and mts_ram.
module min_tracking_stack_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   mode,
    input  logic signed [mts_pkg::VALUE_WIDTH-1:0] value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [mts_pkg::VALUE_WIDTH-1:0] minimum,
    output logic signed [mts_pkg::VALUE_WIDTH-1:0] popped_value,
    output logic [mts_pkg::STATUS_WIDTH-1:0]       status,
    output logic [mts_pkg::PTR_WIDTH-1:0]          occupancy
);

    mts_pkg::mts_cmd_t  cmd;
    mts_pkg::mts_stat_t dp_stat;

    mts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .cmd      (cmd),
        .dp_stat  (dp_stat)
    );

    mts_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_stat      (dp_stat),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .minimum      (minimum),
        .popped_value (popped_value),
        .status       (status),
        .occupancy    (occupancy)
    );

    // Occupancy never exceeds the stack depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= mts_pkg::PTR_WIDTH'(mts_pkg::STACK_DEPTH)))
        else $error("occupancy beyond stack depth");

    // The sequencer is busy right after it takes a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken back to back");

    // A pop on an empty stack leaves it empty and returns nothing
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == mts_pkg::STATUS_EMPTY)
        |-> (occupancy == '0 && popped_value == '0))
        else $error("empty pop result inconsistent");

    // A refused push only happens on a full stack
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == mts_pkg::STATUS_FULL)
        |-> (occupancy == mts_pkg::PTR_WIDTH'(mts_pkg::STACK_DEPTH)))
        else $error("full push flagged below depth");

endmodule

// ===== src/mts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the stack store.
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/mts_ctrl.sv =====
// Sequencer of the min-tracking stack: takes one beat, then runs push or pop.
// Depends on mts_pkg for the command and status types and the mode codes.
module mts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               mode,
    output logic               in_stall,
    output mts_pkg::mts_cmd_t  cmd,
    input  mts_pkg::mts_stat_t dp_stat
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PUSH = 3'b010,
        ST_POP  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    // Decode state into commands and pick the next state
    always_comb
    begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.do_push = 1'b0;
        cmd.do_pop  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (mode == mts_pkg::MODE_POP) ? ST_POP : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.do_push = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.do_pop = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/mts_datapath.sv =====
// Datapath of the min-tracking stack: pointer, minimum, stack store, result register.
// Depends on mts_pkg and instantiates mts_ram for the stack store.
module mts_datapath (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  mts_pkg::mts_cmd_t                        cmd,
    output mts_pkg::mts_stat_t                       dp_stat,
    input  logic signed [mts_pkg::VALUE_WIDTH-1:0]   value,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [mts_pkg::VALUE_WIDTH-1:0]   minimum,
    output logic signed [mts_pkg::VALUE_WIDTH-1:0]   popped_value,
    output logic [mts_pkg::STATUS_WIDTH-1:0]         status,
    output logic [mts_pkg::PTR_WIDTH-1:0]            occupancy
);

    localparam int VW = mts_pkg::VALUE_WIDTH;
    localparam int EW = mts_pkg::ENTRY_WIDTH;
    localparam int AW = mts_pkg::ADDR_WIDTH;
    localparam int PW = mts_pkg::PTR_WIDTH;
    localparam int SW = mts_pkg::STATUS_WIDTH;

    logic [PW-1:0]        sp_reg;
    logic [PW-1:0]        sp_next;
    logic signed [VW-1:0] min_reg;
    logic signed [VW-1:0] min_next;
    logic signed [VW-1:0] value_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [VW-1:0] minimum_reg;
    logic signed [VW-1:0] minimum_next;
    logic signed [VW-1:0] popped_reg;
    logic signed [VW-1:0] popped_next;
    logic [SW-1:0]        status_reg;
    logic [SW-1:0]        status_next;

    logic                 empty;
    logic                 full;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_wdata;
    logic [EW-1:0]        ram_rdata;

    logic signed [EW-1:0] v_ext;
    logic signed [EW-1:0] min_ext;
    logic signed [EW-1:0] push_enc;
    logic signed [EW-1:0] top_entry;
    logic signed [EW-1:0] restore;
    logic                 v_below;
    logic                 top_marks;

    assign empty   = (sp_reg == PW'(0));
    assign full    = (sp_reg == PW'(mts_pkg::STACK_DEPTH));
    assign dp_stat.out_free = !out_valid_reg || !out_stall;

    // Encode and decode arithmetic on entry-width values
    assign v_ext     = EW'(value_reg);
    assign min_ext   = EW'(min_reg);
    assign push_enc  = (v_ext <<< 1) - min_ext;
    assign top_entry = ram_rdata;
    assign restore   = (min_ext <<< 1) - top_entry;
    assign v_below   = (v_ext < min_ext);
    assign top_marks = (top_entry <= min_ext);

    // Stack store: write at the pointer, read the top entry below it
    assign ram_we    = cmd.do_push && !full;
    assign ram_waddr = sp_reg[AW-1:0];
    assign ram_raddr = sp_reg[AW-1:0] - AW'(1);
    assign ram_wdata = (!empty && v_below) ? push_enc : v_ext;

    mts_ram #(
        .WIDTH (EW),
        .DEPTH (mts_pkg::STACK_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Advance pointer and minimum, build the result beat
    always_comb
    begin
        sp_next      = sp_reg;
        min_next     = min_reg;
        minimum_next = minimum_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        if (cmd.do_push)
        begin
            popped_next = '0;
            if (full)
            begin
                status_next  = mts_pkg::STATUS_FULL;
                minimum_next = min_reg;
            end
            else
            begin
                status_next = mts_pkg::STATUS_OK;
                sp_next     = sp_reg + PW'(1);
                if (empty || v_below)
                begin
                    min_next     = value_reg;
                    minimum_next = value_reg;
                end
                else
                begin
                    minimum_next = min_reg;
                end
            end
        end
        else if (cmd.do_pop)
        begin
            minimum_next = min_reg;
            if (empty)
            begin
                status_next = mts_pkg::STATUS_EMPTY;
                popped_next = '0;
            end
            else
            begin
                status_next = mts_pkg::STATUS_OK;
                sp_next     = sp_reg - PW'(1);
                if (top_marks)
                begin
                    popped_next = min_reg;
                    min_next    = restore[VW-1:0];
                end
                else
                begin
                    popped_next = top_entry[VW-1:0];
                end
            end
        end
    end

    // Hold the result beat until it is taken
    always_comb
    begin
        if (cmd.do_push || cmd.do_pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            min_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            value_reg <= value;
        end
        minimum_reg <= minimum_next;
        popped_reg  <= popped_next;
        status_reg  <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign minimum      = minimum_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign occupancy    = sp_reg;

endmodule
